### hw/rtl/lgfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lgfs_pkg
// Shared types and constants of the LED grayscale frame serializer.
// ----------------------------------------------------------------------------
package lgfs_pkg;

   localparam int VAL_W        = 12;
   localparam int DOTS_W       = 9;
   localparam int IDX_W        = 8;
   localparam int BYTE_W       = 8;
   localparam int DRV_W        = 5;   // driver count for up to 511 dots in use
   localparam int PAIR_W       = 4;
   localparam int PART_W       = 2;
   // position width: covers group bases up to 1023 and stores up to 4096 dots
   localparam int POS_W        = 13;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 9;

   localparam int CHANNELS_PER_DRIVER = 24;
   localparam int BYTES_PER_DRIVER    = 36;
   localparam int PAIRS_PER_DRIVER    = BYTES_PER_DRIVER / 3;

   localparam logic [PAIR_W-1:0] PAIR_FIRST   = PAIR_W'(PAIRS_PER_DRIVER - 1);
   localparam logic [PART_W-1:0] PART_LAST    = PART_W'(2);
   localparam logic [DOTS_W-1:0] DOTS_RESET   = DOTS_W'(24);

   // ceil(n / 24) = ((n + 23) * 2731) >> 16, exact for sums below 8192
   localparam logic [11:0] DIV24_RECIP = 12'd2731;
   localparam int          DIV24_SHIFT = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_DOTS_IN_USE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLANK_ENABLE = 1'b1;

   typedef enum logic [2:0] {
      OP_WRITE_DOT  = 3'd0,
      OP_WRITE_RGB  = 3'd1,
      OP_WRITE_RGBW = 3'd2,
      OP_FILL_ONE   = 3'd3,
      OP_FILL_RGB   = 3'd4,
      OP_FILL_RGBW  = 3'd5,
      OP_START      = 3'd6,
      OP_TICK       = 3'd7
   } op_type;

   typedef struct packed {
      logic [2:0]       operation;
      logic [IDX_W-1:0] dot_index;
      logic [VAL_W-1:0] value_a;
      logic [VAL_W-1:0] value_b;
      logic [VAL_W-1:0] value_c;
      logic [VAL_W-1:0] value_d;
   } lgfs_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              is_latch;
      logic              blank_high;
      logic              last_byte;
   } lgfs_rsp_type;

   // store walk: write count entries from base, cycling through the values
   typedef struct packed {
      logic                        start;
      logic [POS_W-1:0]            base;
      logic [POS_W-1:0]            count;
      logic [POS_W-1:0]            limit;
      logic [1:0]                  period_last;
      logic [3:0][VAL_W-1:0]       vals;
   } lgfs_walk_cmd_type;

   function automatic logic [DRV_W-1:0] drivers_for(input logic [DOTS_W-1:0] n);
      logic [DOTS_W:0]    sum;
      logic [DOTS_W+12:0] prod;
      sum  = (DOTS_W + 1)'(n) + (DOTS_W + 1)'(CHANNELS_PER_DRIVER - 1);
      prod = (DOTS_W + 13)'(sum) * (DOTS_W + 13)'(DIV24_RECIP);
      return DRV_W'(prod >> DIV24_SHIFT);
   endfunction

endpackage
`default_nettype wire

### hw/rtl/lgfs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lgfs_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module lgfs_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]                       rd_data_a,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]                       rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule
`default_nettype wire

### hw/rtl/lgfs_writer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lgfs_writer
// Store walker: steps one entry per cycle, writing those below the limit, for
// dot and group writes, fills and the clearing pass that follows reset.
// ----------------------------------------------------------------------------
module lgfs_writer import lgfs_pkg::*; #(
   parameter int MAX_DOTS = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lgfs_walk_cmd_type         cmd,
   output logic                      busy,
   output logic                      wr_en,
   output logic [(MAX_DOTS > 1 ? $clog2(MAX_DOTS) : 1)-1:0] wr_addr,
   output logic [VAL_W-1:0]          wr_data
);

   localparam int AW = (MAX_DOTS > 1) ? $clog2(MAX_DOTS) : 1;

   logic                  busy_ff, busy_in;
   logic [POS_W-1:0]      addr_ff, addr_in;
   logic [POS_W-1:0]      left_ff, left_in;
   logic [POS_W-1:0]      limit_ff, limit_in;
   logic [1:0]            phase_ff, phase_in;
   logic [1:0]            plast_ff, plast_in;
   logic [3:0][VAL_W-1:0] vals_ff, vals_in;

   assign busy    = busy_ff;
   assign wr_en   = busy_ff && (addr_ff < limit_ff);
   assign wr_addr = addr_ff[AW-1:0];
   assign wr_data = vals_ff[phase_ff];

   always_comb begin
      busy_in  = busy_ff;
      addr_in  = addr_ff;
      left_in  = left_ff;
      limit_in = limit_ff;
      phase_in = phase_ff;
      plast_in = plast_ff;
      vals_in  = vals_ff;
      if (busy_ff) begin
         addr_in  = addr_ff + POS_W'(1);
         left_in  = left_ff - POS_W'(1);
         phase_in = (phase_ff == plast_ff) ? 2'd0 : phase_ff + 2'd1;
         busy_in  = (left_ff != POS_W'(1));
      end else if (cmd.start && (cmd.count != '0)) begin
         busy_in  = 1'b1;
         addr_in  = cmd.base;
         left_in  = cmd.count;
         limit_in = cmd.limit;
         phase_in = 2'd0;
         plast_in = cmd.period_last;
         vals_in  = cmd.vals;
      end
   end

   // reset loads a zero fill over the whole store
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         addr_ff  <= '0;
         left_ff  <= POS_W'(MAX_DOTS);
         limit_ff <= POS_W'(MAX_DOTS);
         phase_ff <= 2'd0;
         plast_ff <= 2'd0;
         vals_ff  <= '0;
      end else begin
         busy_ff  <= busy_in;
         addr_ff  <= addr_in;
         left_ff  <= left_in;
         limit_ff <= limit_in;
         phase_ff <= phase_in;
         plast_ff <= plast_in;
         vals_ff  <= vals_in;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/led_grayscale_frame_serializer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_grayscale_frame_serializer_core
// Frame store for 12-bit LED brightness with byte-wise shift-out of frames
// for a chain of 24-channel drivers, followed by a latch result.
//
//   channel | ports                          | moves
//   --------+--------------------------------+---------------------------
//   request | req_valid/req_ready/req_payload| operation, index, values
//   result  | rsp_valid/rsp_ready/rsp_payload| byte or latch marker
//   config  | csr_write_en/csr_index/csr_wdata| dots_in_use, blank_enable
//
// After reset the store is cleared with req_ready low.
// Dot, rgb, rgbw and fill requests hold req_ready low while the store walk
// writes their entries through the single write port of the store.
// A data tick does a store read, then a byte select into the result.
// A request is taken only while the result register is empty or draining.
// ----------------------------------------------------------------------------
module led_grayscale_frame_serializer_core import lgfs_pkg::*; #(
   parameter int MAX_DOTS = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lgfs_req_type           req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lgfs_rsp_type           rsp_payload,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int AW = (MAX_DOTS > 1) ? $clog2(MAX_DOTS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_FETCH = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [DOTS_W-1:0]  dots_ff, dots_in;
   logic               blank_ff, blank_in;
   logic               sending_ff, sending_in;
   logic               latch_ff, latch_in;
   logic [DRV_W-1:0]   driver_ff, driver_in;
   logic [PAIR_W-1:0]  pair_ff, pair_in;
   logic [PART_W-1:0]  part_ff, part_in;
   logic [PART_W-1:0]  part_q_ff, part_q_in;
   logic               lo_ok_ff, lo_ok_in;
   logic               hi_ok_ff, hi_ok_in;
   logic               last_q_ff, last_q_in;
   logic               rsp_valid_ff, rsp_valid_in;
   lgfs_rsp_type       rsp_ff, rsp_in;

   op_type             op;
   logic               req_fire;
   logic               busy;
   logic [DOTS_W-1:0]  eff_dots;
   logic [POS_W-1:0]   eff_pos;
   logic [POS_W-1:0]   idx_pos;
   logic [POS_W-1:0]   frame_base;
   logic [POS_W-1:0]   frame_base_hi;
   logic [DRV_W-1:0]   drivers;
   lgfs_walk_cmd_type  walk_cmd;
   logic               wr_busy;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VAL_W-1:0]   wr_data;
   logic [VAL_W-1:0]   rd_lo;
   logic [VAL_W-1:0]   rd_hi;
   logic [2*VAL_W-1:0] word;

   assign op       = op_type'(req_payload.operation);
   assign busy     = sending_ff || latch_ff;
   assign req_ready = !wr_busy && (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign eff_dots = (POS_W'(dots_ff) > POS_W'(MAX_DOTS)) ? DOTS_W'(MAX_DOTS) : dots_ff;
   assign eff_pos  = POS_W'(eff_dots);
   assign idx_pos  = POS_W'(req_payload.dot_index);
   assign drivers  = drivers_for(eff_dots);

   // driver * 24 + pair * 2
   assign frame_base    = (POS_W'(driver_ff) << 4) + (POS_W'(driver_ff) << 3)
                        + (POS_W'(pair_ff) << 1);
   assign frame_base_hi = frame_base + POS_W'(1);

   always_comb begin
      walk_cmd             = '0;
      walk_cmd.limit       = eff_pos;
      walk_cmd.vals        = {req_payload.value_d, req_payload.value_c,
                              req_payload.value_b, req_payload.value_a};
      walk_cmd.start       = req_fire && !busy && (op != OP_START) && (op != OP_TICK);
      case (op)
         OP_WRITE_DOT: begin
            walk_cmd.base  = idx_pos;
            walk_cmd.count = POS_W'(1);
         end
         OP_WRITE_RGB: begin
            walk_cmd.base        = (idx_pos << 1) + idx_pos;
            walk_cmd.count       = POS_W'(3);
            walk_cmd.period_last = 2'd2;
         end
         OP_WRITE_RGBW: begin
            walk_cmd.base        = idx_pos << 2;
            walk_cmd.count       = POS_W'(4);
            walk_cmd.period_last = 2'd3;
         end
         OP_FILL_ONE: begin
            walk_cmd.count = eff_pos;
         end
         OP_FILL_RGB: begin
            walk_cmd.count       = eff_pos;
            walk_cmd.period_last = 2'd2;
         end
         OP_FILL_RGBW: begin
            walk_cmd.count       = eff_pos;
            walk_cmd.period_last = 2'd3;
         end
         default: begin
            walk_cmd.start = 1'b0;
         end
      endcase
   end

   lgfs_writer #(
      .MAX_DOTS (MAX_DOTS)
   ) u_writer (
      .clock   (clock),
      .reset   (reset),
      .cmd     (walk_cmd),
      .busy    (wr_busy),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   lgfs_ram #(
      .WIDTH (VAL_W),
      .DEPTH (MAX_DOTS)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (frame_base[AW-1:0]),
      .rd_data_a (rd_lo),
      .rd_addr_b (frame_base_hi[AW-1:0]),
      .rd_data_b (rd_hi)
   );

   assign word = {hi_ok_ff ? rd_hi : '0, lo_ok_ff ? rd_lo : '0};

   always_comb begin
      state_in     = state_ff;
      dots_in      = dots_ff;
      blank_in     = blank_ff;
      sending_in   = sending_ff;
      latch_in     = latch_ff;
      driver_in    = driver_ff;
      pair_in      = pair_ff;
      part_in      = part_ff;
      part_q_in    = part_q_ff;
      lo_ok_in     = lo_ok_ff;
      hi_ok_in     = hi_ok_ff;
      last_q_in    = last_q_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_write_en) begin
         case (csr_index)
            CSR_DOTS_IN_USE:  dots_in  = csr_wdata;
            CSR_BLANK_ENABLE: blank_in = csr_wdata[0];
            default: ;
         endcase
      end

      if (state_ff == ST_FETCH) begin
         rsp_valid_in        = 1'b1;
         rsp_in.is_latch     = 1'b0;
         rsp_in.blank_high   = 1'b0;
         rsp_in.last_byte    = last_q_ff;
         case (part_q_ff)
            2'd0:    rsp_in.out_byte = word[23:16];
            2'd1:    rsp_in.out_byte = word[15:8];
            default: rsp_in.out_byte = word[7:0];
         endcase
         state_in = ST_IDLE;
      end

      if (req_fire) begin
         if (op == OP_TICK) begin
            if (sending_ff) begin
               // read address is already on the store; hold the byte select
               part_q_in = part_ff;
               lo_ok_in  = frame_base < eff_pos;
               hi_ok_in  = frame_base_hi < eff_pos;
               last_q_in = 1'b0;
               state_in  = ST_FETCH;
               if (part_ff == PART_LAST) begin
                  part_in = '0;
                  if (pair_ff == '0) begin
                     pair_in = PAIR_FIRST;
                     if (driver_ff == '0) begin
                        sending_in = 1'b0;
                        latch_in   = 1'b1;
                        last_q_in  = 1'b1;
                     end else begin
                        driver_in = driver_ff - DRV_W'(1);
                     end
                  end else begin
                     pair_in = pair_ff - PAIR_W'(1);
                  end
               end else begin
                  part_in = part_ff + PART_W'(1);
               end
            end else if (latch_ff) begin
               latch_in          = 1'b0;
               rsp_valid_in      = 1'b1;
               rsp_in.out_byte   = '0;
               rsp_in.is_latch   = 1'b1;
               rsp_in.blank_high = blank_ff;
               rsp_in.last_byte  = 1'b0;
            end
         end else if ((op == OP_START) && !busy) begin
            part_in = '0;
            pair_in = PAIR_FIRST;
            if (drivers == '0) begin
               latch_in = 1'b1;
            end else begin
               driver_in  = drivers - DRV_W'(1);
               sending_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dots_ff      <= DOTS_RESET;
         blank_ff     <= 1'b0;
         sending_ff   <= 1'b0;
         latch_ff     <= 1'b0;
         driver_ff    <= '0;
         pair_ff      <= PAIR_FIRST;
         part_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dots_ff      <= dots_in;
         blank_ff     <= blank_in;
         sending_ff   <= sending_in;
         latch_ff     <= latch_in;
         driver_ff    <= driver_in;
         pair_ff      <= pair_in;
         part_ff      <= part_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      part_q_ff <= part_q_in;
      lo_ok_ff  <= lo_ok_in;
      hi_ok_ff  <= hi_ok_in;
      last_q_ff <= last_q_in;
      rsp_ff    <= rsp_in;
   end

   a_frame_or_latch : assert property (@(posedge clock) disable iff (reset)
      !(sending_ff && latch_ff))
      else $error("frame send and latch pending at once");

   a_no_write_in_frame : assert property (@(posedge clock) disable iff (reset)
      !(wr_en && busy))
      else $error("store written while a frame is out");

   a_fetch_excludes_walk : assert property (@(posedge clock) disable iff (reset)
      !(wr_busy && (state_ff == ST_FETCH)))
      else $error("store walk overlaps a byte fetch");

   a_last_then_latch : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) && last_q_ff |-> latch_ff && !sending_ff)
      else $error("final byte without a pending latch");

endmodule
`default_nettype wire

### dv/tb_led_grayscale_frame_serializer_core.sv
// ----------------------------------------------------------------------------
// tb_led_grayscale_frame_serializer_core
// Self-checking bench for the LED frame serializer. A behavioral copy of the
// frame store and the shift-out counters predicts every byte and latch
// result. Directed tests cover the extremes, then random traffic runs under
// three back-pressure mixes.
// ----------------------------------------------------------------------------
module tb_led_grayscale_frame_serializer_core;
   import lgfs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DOTS     = 256;
   localparam int SETTLE_CYCLES  = STORE_DOTS + 44;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PRESSURE_HOLD  = 400;
   localparam int PHASE_REQS     = 40;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   lgfs_req_type           req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   lgfs_rsp_type           rsp_payload;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   led_grayscale_frame_serializer_core #(.MAX_DOTS(STORE_DOTS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #4 clock = ~clock;

   // frame model state
   logic [VAL_W-1:0] frame_copy [STORE_DOTS];
   bit               frame_sending;
   bit               latch_owed;
   int unsigned      driver_pos;
   int unsigned      byte_pos;
   logic [DOTS_W-1:0] dots_setting;
   bit               blank_setting;

   lgfs_rsp_type expected_stream[$];

   int send_idle_pct;
   int recv_idle_pct;
   int hold_requests = 0;
   int hold_served = 0;
   int rsp_hold_cycles = 0;
   int mismatches = 0;
   int requests_sent;
   int requests_effective;
   int results_seen = 0;
   int latches_seen = 0;
   int frames_started;
   int csr_writes;
   int quiet_cycles = 0;

   function automatic int unsigned live_dots();
      return (dots_setting > STORE_DOTS) ? STORE_DOTS : dots_setting;
   endfunction

   function automatic logic [VAL_W-1:0] dot_at(int unsigned i);
      if (i < live_dots()) return frame_copy[i];
      return '0;
   endfunction

   function automatic void store_dot(int unsigned i, logic [VAL_W-1:0] v);
      if (i < live_dots()) frame_copy[i] = v;
   endfunction

   function automatic logic [BYTE_W-1:0] next_frame_byte();
      int unsigned pair;
      int unsigned part;
      int unsigned base;
      logic [2*VAL_W-1:0] word;
      pair = PAIRS_PER_DRIVER - 1 - byte_pos / 3;
      part = byte_pos % 3;
      base = driver_pos * CHANNELS_PER_DRIVER + pair * 2;
      word = {dot_at(base + 1), dot_at(base)};
      return BYTE_W'(word >> (8 * (2 - part)));
   endfunction

   // advance the frame model by one accepted request
   task automatic apply_request(input lgfs_req_type r, output bit effective);
      op_type           op;
      lgfs_rsp_type     rsp;
      logic [VAL_W-1:0] vals [4];
      int unsigned      n;
      int unsigned      drivers;
      op = op_type'(r.operation);
      vals[0] = r.value_a;
      vals[1] = r.value_b;
      vals[2] = r.value_c;
      vals[3] = r.value_d;
      rsp = '0;
      effective = 1'b0;
      n = live_dots();
      if (op == OP_TICK) begin
         if (frame_sending) begin
            rsp.out_byte = next_frame_byte();
            byte_pos++;
            if (byte_pos >= BYTES_PER_DRIVER) begin
               byte_pos = 0;
               if (driver_pos == 0) begin
                  frame_sending = 1'b0;
                  latch_owed = 1'b1;
                  rsp.last_byte = 1'b1;
               end else begin
                  driver_pos--;
               end
            end
            expected_stream.push_back(rsp);
            effective = 1'b1;
         end else if (latch_owed) begin
            latch_owed = 1'b0;
            rsp.is_latch = 1'b1;
            rsp.blank_high = blank_setting;
            expected_stream.push_back(rsp);
            effective = 1'b1;
         end
      end else if (!(frame_sending || latch_owed)) begin
         effective = 1'b1;
         case (op)
            OP_WRITE_DOT: store_dot(r.dot_index, vals[0]);
            OP_WRITE_RGB: begin
               for (int k = 0; k < 3; k++) store_dot(int'(r.dot_index) * 3 + k, vals[k]);
            end
            OP_WRITE_RGBW: begin
               for (int k = 0; k < 4; k++) store_dot(int'(r.dot_index) * 4 + k, vals[k]);
            end
            OP_FILL_ONE: begin
               for (int i = 0; i < n; i++) frame_copy[i] = vals[0];
            end
            OP_FILL_RGB: begin
               for (int i = 0; i < n; i++) frame_copy[i] = vals[i % 3];
            end
            OP_FILL_RGBW: begin
               for (int i = 0; i < n; i++) frame_copy[i] = vals[i % 4];
            end
            default: begin
               drivers = (n + CHANNELS_PER_DRIVER - 1) / CHANNELS_PER_DRIVER;
               byte_pos = 0;
               frames_started++;
               if (drivers == 0) begin
                  latch_owed = 1'b1;
               end else begin
                  driver_pos = drivers - 1;
                  frame_sending = 1'b1;
               end
            end
         endcase
      end
   endtask

   function automatic lgfs_req_type make_req(op_type op, logic [IDX_W-1:0] idx,
                                             logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                                             logic [VAL_W-1:0] c, logic [VAL_W-1:0] d);
      lgfs_req_type r;
      r.operation = op;
      r.dot_index = idx;
      r.value_a = a;
      r.value_b = b;
      r.value_c = c;
      r.value_d = d;
      return r;
   endfunction

   // offer one request; valid stays high afterwards until the next call
   task automatic send_req(input lgfs_req_type r, output bit effective);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_payload = r;
      do @(posedge clock); while (req_ready !== 1'b1);
      requests_sent++;
      apply_request(r, effective);
      if (effective) requests_effective++;
   endtask

   task automatic send(input lgfs_req_type r);
      bit eff;
      send_req(r, eff);
   endtask

   task automatic tick();
      send(make_req(OP_TICK, IDX_W'($urandom_range(0, 255)),
                    VAL_W'($urandom_range(0, 4095)), VAL_W'($urandom_range(0, 4095)),
                    VAL_W'($urandom_range(0, 4095)), VAL_W'($urandom_range(0, 4095))));
   endtask

   task automatic finish_frame();
      while (frame_sending || latch_owed) tick();
   endtask

   task automatic release_req();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // drop valid, drain results, then let any fill walk complete
   task automatic settle_block();
      release_req();
      while (expected_stream.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      if (idx == CSR_DOTS_IN_USE) dots_setting = data;
      else blank_setting = data[0];
      csr_writes++;
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic set_config(input int dots, input bit blank);
      settle_block();
      write_csr(CSR_DOTS_IN_USE, CSR_DATA_W'(dots));
      write_csr(CSR_BLANK_ENABLE, CSR_DATA_W'(blank));
   endtask

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return VAL_W'($urandom_range(0, 4095));
      endcase
   endfunction

   function automatic logic [IDX_W-1:0] pick_index(int unsigned span);
      if (span == 0 || $urandom_range(0, 3) == 0) return IDX_W'($urandom_range(0, 255));
      return IDX_W'($urandom_range(0, (span > 256) ? 255 : span - 1));
   endfunction

   function automatic lgfs_req_type random_request();
      int unsigned n;
      int unsigned pick;
      op_type      op;
      n = live_dots();
      pick = $urandom_range(0, 99);
      if (frame_sending || latch_owed) begin
         // mostly ticks; the rest are writes or starts that must be dropped
         op = (pick < 92) ? OP_TICK : op_type'($urandom_range(0, 6));
      end else if (pick < 38) op = OP_WRITE_DOT;
      else if (pick < 52) op = OP_WRITE_RGB;
      else if (pick < 66) op = OP_WRITE_RGBW;
      else if (pick < 70) op = OP_FILL_ONE;
      else if (pick < 73) op = OP_FILL_RGB;
      else if (pick < 76) op = OP_FILL_RGBW;
      else if (pick < 94) op = OP_START;
      else op = OP_TICK;
      case (op)
         OP_WRITE_RGB:  return make_req(op, pick_index((n + 2) / 3), pick_value(),
                                        pick_value(), pick_value(), pick_value());
         OP_WRITE_RGBW: return make_req(op, pick_index((n + 3) / 4), pick_value(),
                                        pick_value(), pick_value(), pick_value());
         default:       return make_req(op, pick_index(n), pick_value(),
                                        pick_value(), pick_value(), pick_value());
      endcase
   endfunction

   task automatic random_config();
      int dots;
      case ($urandom_range(0, 19))
         0: dots = 0;
         1: dots = 1;
         2: dots = STORE_DOTS;
         3: dots = 511;
         4: dots = $urandom_range(STORE_DOTS + 1, 511);
         5, 6, 7: dots = $urandom_range(49, STORE_DOTS);
         default: dots = $urandom_range(1, 48);
      endcase
      set_config(dots, 1'($urandom_range(0, 1)));
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_reset_frame();
      tick();                                   // idle tick: no result
      send(make_req(OP_START, 0, 0, 0, 0, 0));
      finish_frame();
      tick();
   endtask

   task automatic test_dot_writes();
      send(make_req(OP_WRITE_DOT, 0, 12'hFFF, 0, 0, 0));
      send(make_req(OP_WRITE_DOT, 23, 12'hABC, 0, 0, 0));
      send(make_req(OP_WRITE_DOT, 24, 12'h555, 0, 0, 0));   // past count
      send(make_req(OP_WRITE_DOT, 255, 12'h001, 0, 0, 0));
      send(make_req(OP_WRITE_DOT, 1, 12'h000, 12'hFFF, 12'hFFF, 12'hFFF));
      send(make_req(OP_START, 0, 0, 0, 0, 0));
      finish_frame();
   endtask

   task automatic test_group_writes();
      send(make_req(OP_WRITE_RGB, 0, 12'hFFF, 12'h000, 12'hABC, 12'hFFF));
      send(make_req(OP_WRITE_RGB, 7, 12'h123, 12'h456, 12'h789, 0));
      send(make_req(OP_WRITE_RGB, 8, 12'hEEE, 12'hEEE, 12'hEEE, 0));
      send(make_req(OP_WRITE_RGBW, 2, 12'h0F0, 12'hF0F, 12'h5A5, 12'hA5A));
      send(make_req(OP_WRITE_RGBW, 6, 12'hDDD, 12'hDDD, 12'hDDD, 12'hDDD));
      send(make_req(OP_START, 0, 0, 0, 0, 0));
      finish_frame();
      // partial groups straddle the count
      set_config(22, 0);
      send(make_req(OP_WRITE_RGB, 7, 12'h321, 12'h654, 12'h987, 0));
      send(make_req(OP_WRITE_RGBW, 5, 12'hCBA, 12'hFED, 12'h111, 12'h222));
      send(make_req(OP_START, 0, 0, 0, 0, 0));
      finish_frame();
   endtask

   task automatic test_fills();
      set_config(22, 1);
      send(make_req(OP_FILL_ONE, 0, 12'hFFF, 0, 0, 0));
      send(make_req(OP_START, 0, 0, 0, 0, 0));
      finish_frame();
      send(make_req(OP_FILL_RGB, 0, 12'h001, 12'h802, 12'hFF3, 12'hFFF));
      send(make_req(OP_START, 0, 0, 0, 0, 0));
      finish_frame();
      send(make_req(OP_FILL_RGBW, 0, 12'hA00, 12'h0B0, 12'h00C, 12'hDDD));
      set_config(11, 0);
      send(make_req(OP_FILL_ONE, 0, 12'h123, 0, 0, 0));
      set_config(22, 1);                         // dots 11..21 keep the rgbw pattern
      send(make_req(OP_START, 0, 0, 0, 0, 0));
      finish_frame();
   endtask

   task automatic test_busy_ignored();
      set_config(24, 0);
      send(make_req(OP_START, 0, 0, 0, 0, 0));
      repeat (5) tick();
      send(make_req(OP_WRITE_DOT, 3, 12'hBAD, 0, 0, 0));
      send(make_req(OP_FILL_ONE, 0, 12'hBAD, 0, 0, 0));
      send(make_req(OP_START, 0, 0, 0, 0, 0));
      while (frame_sending) tick();
      send(make_req(OP_WRITE_RGB, 1, 12'hBAD, 12'hBAD, 12'hBAD, 0));   // latch still owed
      finish_frame();
      tick();
   endtask

   task automatic test_config_extremes();
      set_config(0, 1);
      send(make_req(OP_WRITE_DOT, 0, 12'h777, 0, 0, 0));
      send(make_req(OP_FILL_ONE, 0, 12'h777, 0, 0, 0));
      send(make_req(OP_START, 0, 0, 0, 0, 0));   // latch only
      finish_frame();
      tick();
      set_config(511, 1);                        // clamps to the store size
      send(make_req(OP_FILL_RGBW, 0, 12'h111, 12'h222, 12'h333, 12'h444));
      send(make_req(OP_WRITE_RGB, 85, 12'hF00, 12'h0F0, 12'h00F, 0));
      send(make_req(OP_WRITE_RGBW, 63, 12'hFFF, 12'h000, 12'hFFF, 12'h000));
      send(make_req(OP_WRITE_DOT, 255, 12'h0A5, 0, 0, 0));
      send(make_req(OP_START, 0, 0, 0, 0, 0));
      finish_frame();
      set_config(1, 1);
      send(make_req(OP_START, 0, 0, 0, 0, 0));
      finish_frame();
   endtask

   task automatic test_config_mid_frame();
      set_config(48, 0);
      send(make_req(OP_FILL_RGB, 0, 12'hFED, 12'hCBA, 12'h987, 0));
      send(make_req(OP_START, 0, 0, 0, 0, 0));
      repeat (20) tick();
      set_config(10, 1);                         // shrink count while the frame runs
      finish_frame();
   endtask

   task automatic test_backpressure();
      set_config(48, 0);
      send(make_req(OP_START, 0, 0, 0, 0, 0));
      hold_requests++;
      repeat (60) tick();
      finish_frame();
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct);
      int           done_reqs;
      bit           eff;
      lgfs_req_type r;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      done_reqs = 0;
      while (done_reqs < PHASE_REQS) begin
         if (!frame_sending && !latch_owed && $urandom_range(0, 39) == 0) random_config();
         r = random_request();
         send_req(r, eff);
         if (eff) done_reqs++;
      end
   endtask

   // ---------------------------------------------------------------- result side

   // a new hold request starts a long stretch with ready low
   always @(negedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served <= hold_requests;
         rsp_ready <= 1'b0;
         rsp_hold_cycles <= PRESSURE_HOLD - 1;
      end else if (rsp_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_cycles <= rsp_hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   function automatic void check_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp, act);
      end
   endfunction

   always @(posedge clock) begin
      lgfs_rsp_type exp;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         results_seen++;
         if (rsp_payload.is_latch === 1'b1) latches_seen++;
         if (expected_stream.size() == 0) begin
            mismatches++;
            $display("%0t ns: unexpected result, expected none, actual 0x%0h",
                     $time, rsp_payload);
         end else begin
            exp = expected_stream.pop_front();
            check_field("out_byte", exp.out_byte, rsp_payload.out_byte);
            check_field("is_latch", exp.is_latch, rsp_payload.is_latch);
            check_field("blank_high", exp.blank_high, rsp_payload.blank_high);
            check_field("last_byte", exp.last_byte, rsp_payload.last_byte);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)
          || csr_write_en) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("led_grayscale_frame_serializer_core verification failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      for (int i = 0; i < STORE_DOTS; i++) frame_copy[i] = '0;
      frame_sending = 1'b0;
      latch_owed = 1'b0;
      driver_pos = 0;
      byte_pos = 0;
      dots_setting = DOTS_RESET;
      blank_setting = 1'b0;
      send_idle_pct = 11;
      recv_idle_pct = 51;
      requests_sent = 0;
      requests_effective = 0;
      frames_started = 0;
      csr_writes = 0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_frame();
      test_dot_writes();
      test_group_writes();
      test_fills();
      test_busy_ignored();
      test_config_extremes();
      test_config_mid_frame();
      test_backpressure();
      test_random_traffic(11, 51);
      test_random_traffic(51, 11);
      test_random_traffic(0, 0);

      finish_frame();
      settle_block();

      $display("Covered %0d requests (%0d took effect), %0d frames, %0d register writes.",
               requests_sent, requests_effective, frames_started, csr_writes);
      $display("Compared %0d results including %0d latch pulses; %0d mismatches.",
               results_seen, latches_seen, mismatches);
      if (mismatches == 0) begin
         $display("led_grayscale_frame_serializer_core verification clean");
      end else begin
         $display("led_grayscale_frame_serializer_core verification failed");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/lgfs_pkg.sv
hw/rtl/lgfs_ram.sv
hw/rtl/lgfs_writer.sv
hw/rtl/led_grayscale_frame_serializer_core.sv
dv/tb_led_grayscale_frame_serializer_core.sv
